// ===== design/pfde_pkg.sv =====
package pfde_pkg;

    // Command codes carried in the kind field.
    localparam logic [2:0] KIND_BOX    = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_GBYTE  = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_SET    = 3'd5;

    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_END    = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_WR,
        ST_OUT
    } pfde_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic rd_issue;  // issue a store read at the current address
        logic wr_issue;  // write the merged byte back
        logic step;      // advance to the next byte of the walk
        logic out_load;  // capture read data into the result register
    } pfde_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk;      // item needs a store walk
        logic is_read;   // item returns a result
        logic last;      // current byte is the last of the walk
        logic clr_busy;  // reset clearing pass still running
    } pfde_sts_t;

    // Start of an aligned span; underflow starts at zero.
    function automatic logic [7:0] aligned_start(input logic [7:0] pos,
                                                 input logic [7:0] size,
                                                 input logic [1:0] mode);
        logic [7:0] off;
        begin
            off = 8'd0;
            if (mode == ALIGN_CENTER) begin
                off = size >> 1;
            end else if (mode == ALIGN_END) begin
                off = size;
            end
            aligned_start = (pos >= off) ? (pos - off) : 8'd0;
        end
    endfunction

endpackage

// ===== design/page_framebuffer_draw_engine.sv =====
// Page-addressed monochrome frame store with a draw engine.
// Input channel s_*: one command per transfer (box fill, glyph header,
// glyph byte, read byte, clear all, set all). Result channel m_*: one
// transfer carrying m_read_data for each read command, none for others.
// Each command is worked by a controller and a datapath around one
// single-port-write store RAM with a registered read.
// A read passes through ST_RD and ST_OUT before m_valid rises, and the next
// command is taken once the controller is back in ST_IDLE. A glyph byte
// touches one or two store bytes; a box fill touches each column-page byte
// in the clipped box; clear and set all touch all SCREEN_COLUMNS *
// SCREEN_PAGES store bytes. Each touched byte is read, merged and written
// back through ST_RD, ST_MOD and ST_WR. Headers, ignored kinds and items
// that write nothing go from ST_RD back to ST_IDLE. The read-modify-write
// loop on the store sets the rate. After reset a clearing pass writes zero
// to every store byte, with s_ready low throughout.
// While a result waits for m_ready, commands are still taken; a further read
// holds in its last cycle until the result register is free, and s_ready
// stays low meanwhile.
module page_framebuffer_draw_engine
    import pfde_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_size_w,
    input  logic [7:0] s_size_h,
    input  logic [1:0] s_align_h,
    input  logic [1:0] s_align_v,
    input  logic       s_polarity,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    pfde_cmd_t cmd;
    pfde_sts_t sts;

    pfde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pfde_dp #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_kind      (s_kind),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_size_w    (s_size_w),
        .s_size_h    (s_size_h),
        .s_align_h   (s_align_h),
        .s_align_v   (s_align_v),
        .s_polarity  (s_polarity),
        .s_data_byte (s_data_byte),
        .m_read_data (m_read_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== design/pfde_ram.sv =====
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/pfde_ctrl.sv =====
module pfde_ctrl
    import pfde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pfde_sts_t sts,
    output pfde_cmd_t cmd
);

    pfde_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                // The result register parts the two sides, so a waiting
                // result does not hold off a new command.
                s_ready = !sts.clr_busy;
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (sts.is_read) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_OUT;
                end else if (sts.walk) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_MOD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                cmd.wr_issue = 1'b1;
                cmd.step     = 1'b1;
                state_next   = sts.last ? ST_IDLE : ST_RD;
            end
            ST_OUT: begin
                // Hold the read data here until the result register is free.
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pfde_dp.sv =====
module pfde_dp
    import pfde_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [2:0] s_kind,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_size_w,
    input  logic [7:0] s_size_h,
    input  logic [1:0] s_align_h,
    input  logic [1:0] s_align_v,
    input  logic       s_polarity,
    input  logic [7:0] s_data_byte,
    output logic [7:0] m_read_data,
    input  pfde_cmd_t  cmd,
    output pfde_sts_t  sts
);

    localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = SCREEN_PAGES * 8;

    // Item registers.
    logic [2:0] kind_reg;
    logic       on_reg;
    logic [7:0] byte_reg;
    logic [8:0] rd_col_reg;
    logic [8:0] rd_pg_reg;

    // Walk registers: column range and row range of the byte walk.
    logic [8:0] col_reg, col_end_reg;
    logic [9:0] row0_reg, row1_reg;   // row span [row0, row1)
    logic [5:0] pg_reg, pg_end_reg;
    logic [5:0] pg_first_reg;

    // Glyph state.
    logic [7:0] g_left_reg, g_top_reg, g_cols_reg, g_rows_reg, g_col_reg;
    logic [5:0] g_page_reg;
    logic       g_active_reg, g_inv_reg;

    // Clearing pass after reset.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [AW-1:0] addr;
    logic [7:0]    rdata, wmask, merged, wdata;
    logic          we;
    logic [AW-1:0] waddr;

    // Span and mask for the current byte.
    logic [9:0]  pbase;
    logic [7:0]  row_mask;
    logic [7:0]  gdata;
    logic [15:0] gshift;
    logic [7:0]  gbits;

    always_comb begin
        pbase = {1'b0, pg_reg, 3'b000};
        for (int b = 0; b < 8; b++) begin
            row_mask[b] = ((pbase + 10'(b)) >= row0_reg) &&
                          ((pbase + 10'(b)) < row1_reg);
        end
    end

    assign addr = AW'(col_reg) * AW'(SCREEN_PAGES) + AW'(pg_reg);
    assign gdata = g_inv_reg ? ~byte_reg : byte_reg;
    // Glyph bits move down by the row offset of the glyph top within its
    // page; the upper half lands in the following store page.
    assign gshift = {8'h00, gdata} << g_top_reg[2:0];
    assign gbits  = (pg_reg == pg_first_reg) ? gshift[7:0] : gshift[15:8];
    assign wmask = row_mask;
    always_comb begin
        if (kind_reg == KIND_GBYTE) begin
            merged = (rdata & ~wmask) | (gbits & wmask);
        end else begin
            merged = on_reg ? (rdata | wmask) : (rdata & ~wmask);
        end
    end

    assign we    = clr_busy_reg || cmd.wr_issue;
    assign waddr = clr_busy_reg ? clr_addr_reg : addr;
    assign wdata = clr_busy_reg ? 8'h00 : merged;

    pfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    assign sts.last     = (pg_reg == pg_end_reg) && (col_reg == col_end_reg);
    assign sts.clr_busy = clr_busy_reg;
    assign sts.is_read  = (kind_reg == KIND_READ);

    // Aligned and clipped spans of the incoming item.
    logic [7:0] ax, ay;
    logic [8:0] bx2, by2c;
    logic [9:0] by2;
    logic [8:0] gcol;
    logic [9:0] grow0, grow1, grel;
    logic [8:0] gpages;
    assign ax    = aligned_start(s_pos_x, s_size_w, s_align_h);
    assign ay    = aligned_start(s_pos_y, s_size_h, s_align_v);
    assign bx2   = ({1'b0, ax} + {1'b0, s_size_w} > 9'(SCREEN_COLUMNS)) ?
                   9'(SCREEN_COLUMNS) : ({1'b0, ax} + {1'b0, s_size_w});
    assign by2   = ({2'b0, ay} + {2'b0, s_size_h} > 10'(ROWS)) ?
                   10'(ROWS) : ({2'b0, ay} + {2'b0, s_size_h});
    assign by2c  = by2[8:0];
    assign gcol  = {1'b0, g_left_reg} + {1'b0, g_col_reg};
    assign grel  = {1'b0, g_page_reg, 3'b000};
    assign grow0 = {2'b0, g_top_reg} + grel;
    assign grow1 = {2'b0, g_top_reg} +
                   ((grel + 10'd8 > {2'b0, g_rows_reg}) ? {2'b0, g_rows_reg} :
                    grel + 10'd8);
    assign gpages = ({1'b0, g_rows_reg} + 9'd7) >> 3;

    // Capture the item and set up the walk.
    logic walk_reg;
    assign sts.walk = walk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            g_active_reg <= 1'b0;
            g_inv_reg    <= 1'b0;
            g_left_reg   <= '0;
            g_top_reg    <= '0;
            g_cols_reg   <= '0;
            g_rows_reg   <= '0;
            g_col_reg    <= '0;
            g_page_reg   <= '0;
            walk_reg     <= 1'b0;
            kind_reg     <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.load) begin
                kind_reg   <= s_kind;
                byte_reg   <= s_data_byte;
                rd_col_reg <= {1'b0, s_pos_x};
                rd_pg_reg  <= {1'b0, s_pos_y};
                case (s_kind)
                    KIND_BOX: begin
                        on_reg      <= s_polarity;
                        col_reg     <= {1'b0, ax};
                        col_end_reg <= bx2 - 9'd1;
                        row0_reg    <= {2'b0, ay};
                        row1_reg    <= by2;
                        pg_reg      <= {1'b0, ay[7:3]};
                        pg_first_reg <= {1'b0, ay[7:3]};
                        pg_end_reg  <= 6'((by2 - 10'd1) >> 3);
                        walk_reg    <= ({1'b0, ax} < bx2) &&
                                       ({2'b0, ay} < by2) && (by2c != 9'd0);
                    end
                    KIND_CLEAR, KIND_SET: begin
                        on_reg      <= (s_kind == KIND_SET);
                        col_reg     <= '0;
                        col_end_reg <= 9'(SCREEN_COLUMNS - 1);
                        row0_reg    <= '0;
                        row1_reg    <= 10'(ROWS);
                        pg_reg      <= '0;
                        pg_first_reg <= '0;
                        pg_end_reg  <= 6'(SCREEN_PAGES - 1);
                        walk_reg    <= 1'b1;
                    end
                    KIND_HEADER: begin
                        g_left_reg   <= ax;
                        g_top_reg    <= ay;
                        g_cols_reg   <= s_size_w;
                        g_rows_reg   <= s_size_h;
                        g_col_reg    <= '0;
                        g_page_reg   <= '0;
                        g_inv_reg    <= s_polarity;
                        g_active_reg <= (s_size_w != 8'd0) && (s_size_h != 8'd0);
                        walk_reg     <= 1'b0;
                    end
                    KIND_GBYTE: begin
                        if (g_active_reg) begin
                            // One byte may straddle two store pages.
                            col_reg     <= gcol;
                            col_end_reg <= gcol;
                            row0_reg    <= grow0;
                            row1_reg    <= (grow1 > 10'(ROWS)) ? 10'(ROWS) : grow1;
                            pg_reg      <= grow0[8:3];
                            pg_first_reg <= grow0[8:3];
                            pg_end_reg  <= 6'((((grow1 > 10'(ROWS)) ? 10'(ROWS) : grow1)
                                               - 10'd1) >> 3);
                            walk_reg    <= (gcol < 9'(SCREEN_COLUMNS)) &&
                                           (grow0 < 10'(ROWS));
                            // Advance glyph progress.
                            if (9'(g_page_reg) + 9'd1 >= gpages) begin
                                g_page_reg <= '0;
                                if (9'(g_col_reg) + 9'd1 >= 9'(g_cols_reg)) begin
                                    g_col_reg    <= '0;
                                    g_active_reg <= 1'b0;
                                end else begin
                                    g_col_reg <= g_col_reg + 8'd1;
                                end
                            end else begin
                                g_page_reg <= g_page_reg + 6'd1;
                            end
                        end else begin
                            walk_reg <= 1'b0;
                        end
                    end
                    KIND_READ: begin
                        // Point the read address at the requested byte.
                        col_reg  <= {1'b0, s_pos_x};
                        pg_reg   <= s_pos_y[5:0];
                        walk_reg <= 1'b0;
                    end
                    default: begin
                        walk_reg <= 1'b0;
                    end
                endcase
            end
            // Walk order: pages within a column, then next column.
            if (cmd.step) begin
                if (pg_reg == pg_end_reg) begin
                    pg_reg  <= pg_first_reg;
                    col_reg <= col_reg + 9'd1;
                end else begin
                    pg_reg <= pg_reg + 6'd1;
                end
            end
            if (cmd.out_load) begin
                m_read_data <= ((rd_col_reg < 9'(SCREEN_COLUMNS)) &&
                                (rd_pg_reg < 9'(SCREEN_PAGES))) ? rdata : 8'h00;
            end
        end
    end

endmodule

// ===== design/pfde_checker.sv =====
module pfde_checker
    import pfde_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_kind,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data
);

    // A waiting result keeps its data until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("result changed while stalled");

    // Handshake outputs are always known once out of reset.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid}))
        else $error("handshake output unknown");

    // No two commands are taken back to back.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back-to-back accept");

    // A taken read is followed by a result on offer.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_READ |-> ##3 m_valid)
        else $error("read result missing");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data)
);

// ===== tb/sv/page_framebuffer_draw_engine_test.sv =====
`timescale 1ns / 100ps

module page_framebuffer_draw_engine_test
    import pfde_pkg::*;
;

    localparam int COLS  = 128;
    localparam int PAGES = 8;
    localparam int ROWS  = PAGES * 8;

    // One command as it travels on the input channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] size_w;
        logic [7:0] size_h;
        logic [1:0] align_h;
        logic [1:0] align_v;
        logic       polarity;
        logic [7:0] data_byte;
    } draw_cmd_t;

    // Directed row: a command and, where known up front, the read value.
    typedef struct {
        draw_cmd_t  cmd;
        bit         fixed;
        logic [7:0] value;
    } draw_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    draw_cmd_t  s_cmd = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;

    // Shadow copy of the screen and of glyph progress.
    logic [7:0] shadow_store [COLS * PAGES];
    logic [7:0] gl_left, gl_top, gl_cols, gl_rows, gl_col, gl_page;
    bit         gl_active, gl_invert;

    logic [7:0] read_queue [$];
    int         mismatches = 0;
    bit         hold_off = 1'b0;
    bit         stim_done = 1'b0;

    always #5 aclk = ~aclk;

    page_framebuffer_draw_engine i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_cmd.kind),
        .s_pos_x     (s_cmd.pos_x),
        .s_pos_y     (s_cmd.pos_y),
        .s_size_w    (s_cmd.size_w),
        .s_size_h    (s_cmd.size_h),
        .s_align_h   (s_cmd.align_h),
        .s_align_v   (s_cmd.align_v),
        .s_polarity  (s_cmd.polarity),
        .s_data_byte (s_cmd.data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

    function automatic int span_start(int pos, int size, logic [1:0] mode);
        int off;
        off = (mode == ALIGN_CENTER) ? size / 2 : (mode == ALIGN_END) ? size : 0;
        return (pos >= off) ? pos - off : 0;
    endfunction

    function automatic void paint(int col, int row, bit on);
        int idx;
        if (col >= COLS || row >= ROWS) return;
        idx = col * PAGES + row / 8;
        shadow_store[idx][row % 8] = on;
    endfunction

    // Apply one command to the shadow screen; queue the value of a read.
    function automatic void predict_draw(draw_cmd_t c);
        int x1, y1, x2, y2, pages, rel;
        logic [7:0] bits;
        case (c.kind)
            KIND_BOX: begin
                x1 = span_start(c.pos_x, c.size_w, c.align_h);
                y1 = span_start(c.pos_y, c.size_h, c.align_v);
                x2 = (x1 + c.size_w > COLS) ? COLS : x1 + c.size_w;
                y2 = (y1 + c.size_h > ROWS) ? ROWS : y1 + c.size_h;
                for (int i = x1; i < x2; i++)
                    for (int j = y1; j < y2; j++) paint(i, j, c.polarity);
            end
            KIND_HEADER: begin
                gl_left   = 8'(span_start(c.pos_x, c.size_w, c.align_h));
                gl_top    = 8'(span_start(c.pos_y, c.size_h, c.align_v));
                gl_cols   = c.size_w;
                gl_rows   = c.size_h;
                gl_col    = '0;
                gl_page   = '0;
                gl_invert = c.polarity;
                gl_active = (c.size_w != 0) && (c.size_h != 0);
            end
            KIND_GBYTE: begin
                if (gl_active) begin
                    pages = (int'(gl_rows) + 7) / 8;
                    bits = gl_invert ? ~c.data_byte : c.data_byte;
                    for (int b = 0; b < 8; b++) begin
                        rel = int'(gl_page) * 8 + b;
                        if (rel < gl_rows)
                            paint(int'(gl_left) + int'(gl_col), int'(gl_top) + rel, bits[b]);
                    end
                    gl_page = (gl_page + 8'd1) & 8'h3f;
                    if (gl_page >= pages) begin
                        gl_page = '0;
                        gl_col = gl_col + 8'd1;
                        if (gl_col >= gl_cols) begin
                            gl_col = '0;
                            gl_active = 1'b0;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (c.pos_x < COLS && c.pos_y < PAGES)
                    read_queue.push_back(shadow_store[c.pos_x * PAGES + c.pos_y]);
                else
                    read_queue.push_back(8'h00);
            end
            KIND_CLEAR: foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            KIND_SET:   foreach (shadow_store[i]) shadow_store[i] = 8'hff;
            default: ;
        endcase
    endfunction

    function automatic draw_cmd_t make_cmd(logic [2:0] k, int x, int y, int w, int h,
                                           int ah, int av, bit pol, int d);
        draw_cmd_t c;
        c.kind = k; c.pos_x = 8'(x); c.pos_y = 8'(y); c.size_w = 8'(w); c.size_h = 8'(h);
        c.align_h = 2'(ah); c.align_v = 2'(av); c.polarity = pol; c.data_byte = 8'(d);
        return c;
    endfunction

    function automatic draw_cmd_t rand_noise();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(draw_cmd_t)-1:0];
    endfunction

    // Place one command on the channel and wait for its transfer.
    task automatic send_cmd(draw_cmd_t c);
        s_cmd   <= c;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_draw(c);
    endtask

    // Burst pacing: end a burst with a random gap.
    int burst_left = 0;
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic draw_cmd_t rand_draw(bit small_box);
        draw_cmd_t c;
        c = rand_noise();
        c.kind = (c.kind > KIND_SET && $urandom_range(0, 7) != 0) ? KIND_READ : c.kind;
        if (c.kind == KIND_READ && $urandom_range(0, 7) != 0) begin
            c.pos_x = 8'($urandom_range(0, COLS - 1));
            c.pos_y = 8'($urandom_range(0, PAGES - 1));
        end
        if (c.kind == KIND_BOX && small_box) begin
            c.size_w = 8'($urandom_range(0, 20));
            c.size_h = 8'($urandom_range(0, 24));
            if ($urandom_range(0, 3) != 0) begin
                c.pos_x = 8'($urandom_range(0, COLS + 10));
                c.pos_y = 8'($urandom_range(0, ROWS + 10));
            end
        end
        if ((c.kind == KIND_CLEAR || c.kind == KIND_SET) && $urandom_range(0, 7) != 0)
            c.kind = KIND_READ;
        return c;
    endfunction

    // Stimulus: directed table, reads under a receiver hold-off, then mostly glyph sequences with reads.
    initial begin : stimulus
        draw_row_t  rows [$];
        draw_cmd_t  c;
        int         n, w, h, nbytes;

        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
        gl_left = '0; gl_top = '0; gl_cols = '0; gl_rows = '0; gl_col = '0; gl_page = '0;
        gl_active = 1'b0; gl_invert = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        rows = '{
            '{make_cmd(KIND_READ,   0,   0,   0,   0, 0, 0, 0, 0),   1, 8'h00},
            '{make_cmd(KIND_READ, 255, 255, 255, 255, 3, 3, 1, 255), 1, 8'h00},
            '{make_cmd(KIND_SET,    0,   0,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_READ, 127,   7,   0,   0, 0, 0, 0, 0),   1, 8'hff},
            '{make_cmd(KIND_READ, 128,   0,   0,   0, 0, 0, 0, 0),   1, 8'h00},
            '{make_cmd(KIND_READ,   0,   8,   0,   0, 0, 0, 0, 0),   1, 8'h00},
            '{make_cmd(KIND_BOX,  200, 200, 255, 255, 2, 2, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_READ,  10,   3,   0,   0, 0, 0, 0, 0),   1, 8'h00},
            '{make_cmd(KIND_BOX,   64,  32,  10,  12, 1, 1, 1, 0),   0, 8'h00},
            '{make_cmd(KIND_BOX,  126,  60,   9,   9, 3, 3, 1, 0),   0, 8'h00},
            '{make_cmd(KIND_READ,  64,   4,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_READ, 127,   7,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_GBYTE,  0,   0,   0,   0, 0, 0, 0, 8'ha5), 0, 8'h00},
            '{make_cmd(KIND_HEADER, 5,  20,   0,   7, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_HEADER,125, 61,   3,  11, 0, 0, 1, 0),   0, 8'h00},
            '{make_cmd(KIND_GBYTE,  0,   0,   0,   0, 0, 0, 0, 8'h0f), 0, 8'h00},
            '{make_cmd(KIND_READ, 125,   7,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_GBYTE,  0,   0,   0,   0, 0, 0, 0, 8'hff), 0, 8'h00},
            '{make_cmd(KIND_HEADER, 2,   1,   4,   2, 2, 2, 0, 0),   0, 8'h00},
            '{make_cmd(3'd6,        1,   1,   1,   1, 1, 1, 1, 1),   0, 8'h00},
            '{make_cmd(3'd7,        0,   0,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_GBYTE,  0,   0,   0,   0, 0, 0, 0, 8'h03), 0, 8'h00},
            '{make_cmd(KIND_READ,   0,   0,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_CLEAR,  0,   0,   0,   0, 0, 0, 0, 0),   0, 8'h00},
            '{make_cmd(KIND_READ,  64,   4,   0,   0, 0, 0, 0, 0),   1, 8'h00}
        };
        foreach (rows[i]) begin
            send_cmd(rows[i].cmd);
            if (rows[i].fixed && read_queue[$] != rows[i].value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: value %h does not match %h",
                             i, read_queue[$], rows[i].value);
            end
            pace();
        end

        // Long receiver hold-off while commands keep arriving.
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++) send_cmd(make_cmd(KIND_READ, i, i % 8, 0, 0, 0, 0, 0, 0));

        n = 0;
        while (n < 1100) begin
            if ($urandom_range(0, 3) != 0) begin
                // Glyph with random content and a byte count near its size, other commands and reads mixed in.
                c = rand_noise();
                c.kind = KIND_HEADER;
                c.size_w = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(1, 6));
                c.size_h = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(1, 20));
                if ($urandom_range(0, 3) != 0) begin
                    c.pos_x = 8'($urandom_range(0, COLS + 8));
                    c.pos_y = 8'($urandom_range(0, ROWS + 8));
                end
                send_cmd(c); pace(); n++;
                w = c.size_w; h = c.size_h;
                nbytes = w * ((h + 7) / 8);
                if (nbytes > 24) nbytes = $urandom_range(1, 24);
                nbytes = nbytes + $urandom_range(0, 2) - ($urandom_range(0, 7) == 0 ? 1 : 0);
                for (int k = 0; k < nbytes; k++) begin
                    c = rand_noise();
                    c.kind = KIND_GBYTE;
                    if ($urandom_range(0, 5) == 0) c = rand_draw(1'b1);
                    send_cmd(c); pace(); n++;
                end
                c = rand_noise();
                c.kind = KIND_READ;
                c.pos_x = 8'($urandom_range(0, COLS - 1));
                c.pos_y = 8'($urandom_range(0, PAGES - 1));
                send_cmd(c); pace(); n++;
            end else begin
                send_cmd(rand_draw(1'b1)); pace(); n++;
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: one long hold-off, otherwise a stall pattern of its own.
    initial begin : receiver
        int cnt;
        int held;
        cnt = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold_off && held < 400) begin
                held++;
                m_ready <= 1'b0;
            end else if (((cnt / 64) % 3) == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            cnt++;
        end
    end

    // Compare each result transfer with the oldest queued value.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (read_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_read_data);
            end else begin
                if (m_read_data !== read_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read_data: expected %h got %h", read_queue[0], m_read_data);
                end
                void'(read_queue.pop_front());
            end
        end
    end

    // End of run once all results are in.
    initial begin : finisher
        wait (stim_done);
        while (read_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #40ms;
        $display("FAIL");
        $finish;
    end

endmodule
